>>> rtl/ntprc_pkg.sv
// Shared types, field layout and constants for the NTP reply checker.
`default_nettype none

package ntprc_pkg;

  // Samples counted per round before the success count saturates.
  localparam int unsigned ROUND_LIMIT = 8;
  localparam int unsigned CNT_W       = 4;

  localparam int unsigned TS_W   = 64;
  localparam int unsigned DLY_W  = 63;
  localparam int unsigned CFG_W  = 8;
  localparam int unsigned IDX_W  = 1;

  // Input item layout in in_tdata, lowest bit first.
  localparam int unsigned I_MODE_LO  = 0;
  localparam int unsigned I_STRAT_LO = 8;
  localparam int unsigned I_ECHO_LO  = 16;
  localparam int unsigned I_T1_LO    = 48;
  localparam int unsigned I_T2_LO    = 112;
  localparam int unsigned I_T3_LO    = 176;
  localparam int unsigned I_T4_LO    = 240;
  localparam int unsigned I_ELAP_LO  = 304;
  localparam int unsigned I_USED_W   = 367;
  localparam int unsigned IN_DATA_W  = 368;
  localparam int unsigned IN_USER_W  = 2;

  // Result item layout in out_tdata, lowest bit first.
  localparam int unsigned O_USED_W   = 323;
  localparam int unsigned OUT_DATA_W = 328;
  localparam int unsigned OUT_USER_W = 4;

  // Mode byte fields.
  localparam logic [1:0] LEAP_UNSYNC = 2'd3;
  localparam logic [2:0] MODE_SERVER = 3'd4;
  localparam logic [2:0] MODE_BCAST  = 3'd5;

  localparam logic [CFG_W-1:0] STRATUM_LIMIT_RST = 8'd15;
  localparam logic [CFG_W-1:0] SKEW_LIMIT_RST    = 8'd1;

  typedef enum logic [IDX_W-1:0] {
    REG_STRATUM_LIMIT = 1'b0,
    REG_ORIGIN_SKEW   = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    RX_OK      = 2'd0,
    RX_TIMEOUT = 2'd1,
    RX_SHORT   = 2'd2,
    RX_UNUSED  = 2'd3
  } rx_status_t;

  typedef enum logic [3:0] {
    ST_OK        = 4'd0,
    ST_TIMEOUT   = 4'd1,
    ST_SHORT     = 4'd2,
    ST_UNSYNCED  = 4'd3,
    ST_VERSION   = 4'd4,
    ST_MODE      = 4'd5,
    ST_KOD       = 4'd6,
    ST_STRATUM   = 4'd7,
    ST_ORIGIN    = 4'd8,
    ST_ZERO_XMIT = 4'd9
  } sample_status_t;

endpackage

`default_nettype wire

>>> rtl/ntp_reply_check_offset_delay.sv
// NTP reply checker: header checks, on-wire offset and delay, min-delay round filter.
// Items pass through the input register, then the result register.
// Throughput: one item per cycle unless out_tready stalls the result register; the compute path
// is a 64-bit subtract, then a 66-bit subtract and clamp for the delay, a 65-bit add for the
// offset, then a 64-bit add and a 63-bit compare for the filter.
// Reset (rst_n low, synchronous) empties both stages, clears the round state and sets
// stratum_limit to 15 and origin_skew_limit to 1. No clearing pass; the block is ready at once.
`default_nettype none

module ntp_reply_check_offset_delay (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // Configuration write port.
  input  wire logic                               cfg_we,
  input  wire logic [ntprc_pkg::IDX_W-1:0]        cfg_index,
  input  wire logic [ntprc_pkg::CFG_W-1:0]        cfg_data,
  // Input items.
  input  wire logic                               in_tvalid,
  output      logic                               in_tready,
  // in_tdata, low to high: mode_byte[7:0], stratum[15:8], echoed_origin_seconds[47:16],
  // request_time[111:48], server_receive_time[175:112], server_transmit_time[239:176],
  // reply_time[303:240], elapsed_monotonic[366:304], zero pad[367].
  input  wire logic [ntprc_pkg::IN_DATA_W-1:0]    in_tdata,
  // in_tuser: receive_status[1:0].
  input  wire logic [ntprc_pkg::IN_USER_W-1:0]    in_tuser,
  input  wire logic                               in_tlast,
  // Result items.
  output      logic                               out_tvalid,
  input  wire logic                               out_tready,
  // out_tdata, low to high: sample_delay[62:0], sample_offset[126:63], round_ok[127],
  // best_delay[190:128], best_offset[254:191], best_corrected_time[318:255],
  // valid_total[322:319], zero pad[327:323].
  output      logic [ntprc_pkg::OUT_DATA_W-1:0]   out_tdata,
  // out_tuser: sample_status[3:0].
  output      logic [ntprc_pkg::OUT_USER_W-1:0]   out_tuser,
  // out_tlast: round_done.
  output      logic                               out_tlast
);

  import ntprc_pkg::*;

  localparam logic [DLY_W-1:0] DLY_MAX = {DLY_W{1'b1}};

  // Configuration registers.
  logic [CFG_W-1:0] stratum_limit_r;
  logic [CFG_W-1:0] skew_limit_r;

  // Input stage.
  logic                  s1_valid_r;
  logic [I_USED_W-1:0]   s1_data_r;
  logic [IN_USER_W-1:0]  s1_user_r;
  logic                  s1_last_r;

  // Result stage.
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic [OUT_USER_W-1:0] out_user_r;
  logic                  out_last_r;

  // Round state.
  logic             best_valid_r, best_valid_nxt;
  logic [DLY_W-1:0] best_delay_r, best_delay_nxt;
  logic [TS_W-1:0]  best_offset_r, best_offset_nxt;
  logic [TS_W-1:0]  best_corr_r, best_corr_nxt;
  logic [CNT_W-1:0] valid_count_r, valid_count_nxt;

  logic in_fire;
  logic s1_adv;

  // Fields of the item in the input stage.
  logic [7:0]       mode_byte;
  logic [7:0]       stratum;
  logic [31:0]      echoed;
  logic [TS_W-1:0]  t1, t2, t3, t4;
  logic [DLY_W-1:0] elapsed;
  logic [1:0]       leap;
  logic [2:0]       version;
  logic [2:0]       mode;
  logic [31:0]      skew;

  sample_status_t   status;
  logic             sample_ok;

  logic [TS_W-1:0]  srv_hold;
  logic [TS_W-1:0]  diff_a, diff_b;
  logic [TS_W+1:0]  delay_wide;
  logic [DLY_W-1:0] delay_clamped;
  logic [TS_W:0]    offset_sum;
  logic [TS_W-1:0]  offset_val;
  logic [TS_W-1:0]  corr_val;
  logic             take_best;

  logic [DLY_W-1:0] o_delay;
  logic [TS_W-1:0]  o_offset;
  logic             o_round_ok;
  logic [DLY_W-1:0] o_best_delay;
  logic [TS_W-1:0]  o_best_offset;
  logic [TS_W-1:0]  o_best_corr;
  logic [CNT_W-1:0] o_count;

  // Handshake. The input stage moves on whenever the result register is empty or being
  // drained, so a new item can enter in the same cycle the previous one leaves.
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_fire   = in_tvalid && in_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // The user must make configuration writes only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stratum_limit_r <= STRATUM_LIMIT_RST;
      skew_limit_r    <= SKEW_LIMIT_RST;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_STRATUM_LIMIT: stratum_limit_r <= cfg_data;
        REG_ORIGIN_SKEW:   skew_limit_r    <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_data_r <= in_tdata[I_USED_W-1:0];
      s1_user_r <= in_tuser;
      s1_last_r <= in_tlast;
    end
  end

  // Unpack the held item.
  assign mode_byte = s1_data_r[I_MODE_LO  +: 8];
  assign stratum   = s1_data_r[I_STRAT_LO +: 8];
  assign echoed    = s1_data_r[I_ECHO_LO  +: 32];
  assign t1        = s1_data_r[I_T1_LO    +: TS_W];
  assign t2        = s1_data_r[I_T2_LO    +: TS_W];
  assign t3        = s1_data_r[I_T3_LO    +: TS_W];
  assign t4        = s1_data_r[I_T4_LO    +: TS_W];
  assign elapsed   = s1_data_r[I_ELAP_LO  +: DLY_W];

  assign leap    = mode_byte[7:6];
  assign version = mode_byte[5:3];
  assign mode    = mode_byte[2:0];

  // Distance between the seconds we sent and the seconds the server echoed back.
  assign skew = (echoed > t1[63:32]) ? (echoed - t1[63:32]) : (t1[63:32] - echoed);

  // Checks in priority order; the first failing one sets the status. The unused receive
  // code counts as a timeout.
  always_comb begin
    status = ST_OK;
    case (rx_status_t'(s1_user_r))
      RX_TIMEOUT, RX_UNUSED: status = ST_TIMEOUT;
      RX_SHORT:              status = ST_SHORT;
      RX_OK: begin
        if (leap == LEAP_UNSYNC) begin
          status = ST_UNSYNCED;
        end else if (!(version inside {3'd3, 3'd4})) begin
          status = ST_VERSION;
        end else if (mode != MODE_SERVER && mode != MODE_BCAST) begin
          status = ST_MODE;
        end else if (stratum == 8'd0) begin
          status = ST_KOD;
        end else if (stratum > stratum_limit_r) begin
          status = ST_STRATUM;
        end else if (skew > {24'd0, skew_limit_r}) begin
          status = ST_ORIGIN;
        end else if (t3[63:32] == 32'd0) begin
          status = ST_ZERO_XMIT;
        end else begin
          status = ST_OK;
        end
      end
      default: status = ST_TIMEOUT;
    endcase
  end

  assign sample_ok = (status == ST_OK);

  // On-wire arithmetic. All timestamp differences wrap modulo 2^64 and are read as signed,
  // which keeps the result correct across NTP era rollovers.
  assign srv_hold = t3 - t2;
  assign diff_a   = t2 - t1;
  assign diff_b   = t3 - t4;

  // Delay is elapsed minus the server hold time. In 66 bits this cannot overflow, so the
  // sign bit catches a negative delay and bits 64:63 catch a saturating one.
  assign delay_wide = {3'b000, elapsed} - {{2{srv_hold[TS_W-1]}}, srv_hold};

  always_comb begin
    if (delay_wide[TS_W+1]) begin
      delay_clamped = '0;
    end else if (|delay_wide[TS_W:DLY_W]) begin
      delay_clamped = DLY_MAX;
    end else begin
      delay_clamped = delay_wide[DLY_W-1:0];
    end
  end

  // Offset is the 65-bit signed sum halved with rounding toward minus infinity; the
  // halved value always fits in 64 bits.
  assign offset_sum = {diff_a[TS_W-1], diff_a} + {diff_b[TS_W-1], diff_b};
  assign offset_val = offset_sum[TS_W:1];
  assign corr_val   = t4 + offset_val;

  // Minimum-delay filter: a strictly smaller delay replaces the kept sample, so the first
  // of equal delays wins.
  assign take_best = sample_ok && (!best_valid_r || (delay_clamped < best_delay_r));

  always_comb begin
    best_valid_nxt  = best_valid_r;
    best_delay_nxt  = best_delay_r;
    best_offset_nxt = best_offset_r;
    best_corr_nxt   = best_corr_r;
    valid_count_nxt = valid_count_r;
    if (take_best) begin
      best_valid_nxt  = 1'b1;
      best_delay_nxt  = delay_clamped;
      best_offset_nxt = offset_val;
      best_corr_nxt   = corr_val;
    end
    if (sample_ok && (valid_count_r < CNT_W'(ROUND_LIMIT))) begin
      valid_count_nxt = valid_count_r + CNT_W'(1);
    end
  end

  // Per-sample fields are zero for a rejected reply. Round fields show the kept sample,
  // including this one, only on the item that closes the round; an empty round reads zero.
  assign o_delay       = sample_ok ? delay_clamped : '0;
  assign o_offset      = sample_ok ? offset_val : '0;
  assign o_round_ok    = s1_last_r && best_valid_nxt;
  assign o_best_delay  = o_round_ok ? best_delay_nxt : '0;
  assign o_best_offset = o_round_ok ? best_offset_nxt : '0;
  assign o_best_corr   = o_round_ok ? best_corr_nxt : '0;
  assign o_count       = s1_last_r ? valid_count_nxt : '0;

  // Round state follows the items that reach the result register; closing a round clears it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r  <= 1'b0;
      valid_count_r <= '0;
    end else if (s1_adv) begin
      best_valid_r  <= s1_last_r ? 1'b0 : best_valid_nxt;
      valid_count_r <= s1_last_r ? '0 : valid_count_nxt;
    end
  end

  // The kept values are only read while best_valid_r is set.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      best_delay_r  <= best_delay_nxt;
      best_offset_r <= best_offset_nxt;
      best_corr_r   <= best_corr_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data_r <= {(OUT_DATA_W - O_USED_W)'(0), o_count, o_best_corr, o_best_offset,
                     o_best_delay, o_round_ok, o_offset, o_delay};
      out_user_r <= status;
      out_last_r <= s1_last_r;
    end
  end

endmodule

`default_nettype wire
